// ----- design/rwu_pkg.sv -----
// Package: shared types and constants for the RPROP weight update unit
`timescale 1ns / 1ps

package rwu_pkg;

    localparam int DATA_W    = 32;
    localparam int FACTOR_W  = 16;
    localparam int FRAC_W    = 12;
    localparam int PROD_W    = DATA_W + FACTOR_W;
    localparam int SCALED_W  = PROD_W - FRAC_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [FACTOR_W-1:0] GROW_RESET    = 16'd4915;
    localparam logic [FACTOR_W-1:0] SHRINK_RESET  = 16'd2048;
    localparam logic [DATA_W-1:0]   CEILING_RESET = 32'd3276800;
    localparam logic [DATA_W-1:0]   FLOOR_RESET   = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROW    = 2'd0,
        REG_SHRINK  = 2'd1,
        REG_CEILING = 2'd2,
        REG_FLOOR   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CASE_HOLD   = 2'd0,
        CASE_GROW   = 2'd1,
        CASE_SHRINK = 2'd2
    } t_case;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_ADD  = 2'd1,
        DIR_SUB  = 2'd2
    } t_dir;

endpackage

// ----- design/rwu_in_if.sv -----
// Interface: input item channel of the RPROP weight update unit
`timescale 1ns / 1ps

interface rwu_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] prior_gradient;
    logic signed [31:0] batch_gradient;
    logic        [31:0] step_in;
    logic signed [31:0] weight_in;

    modport source (
        output valid, prior_gradient, batch_gradient, step_in, weight_in,
        input  ready
    );
    modport sink (
        input  valid, prior_gradient, batch_gradient, step_in, weight_in,
        output ready
    );
endinterface

// ----- design/rwu_out_if.sv -----
// Interface: result channel of the RPROP weight update unit
`timescale 1ns / 1ps

interface rwu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] weight_out;
    logic        [31:0] step_out;
    logic signed [31:0] prior_gradient_out;

    modport source (
        output valid, weight_out, step_out, prior_gradient_out,
        input  ready
    );
    modport sink (
        input  valid, weight_out, step_out, prior_gradient_out,
        output ready
    );
endinterface

// ----- design/rprop_weight_update_unit.sv -----
// Top level: four-stage pipelined RPROP per-weight update with config registers
//
// One weight enters per cycle while the result side does not stall and
// passes through stages for sign decode, the 32x16 step-factor multiply,
// step clamping and the saturating weight add. Each stage holds its item
// while the next is full, so a result-side stall backs up to the input
// without loss. Gradients and weights are signed Q16.16, the step unsigned
// Q16.16, the grow and shrink factors unsigned Q4.12; the scaled step is
// truncated. The user must write configuration through i_cfg_we, i_cfg_idx
// and i_cfg_data only while no item is in flight; the block has no guard.
`timescale 1ns / 1ps

module rprop_weight_update_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rwu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rwu_pkg::DATA_W-1:0]        i_cfg_data,
    rwu_in_if.sink                            i_item,
    rwu_out_if.source                         o_result
);

    logic [rwu_pkg::FACTOR_W-1:0] r_grow;
    logic [rwu_pkg::FACTOR_W-1:0] r_shrink;
    logic [rwu_pkg::DATA_W-1:0]   r_ceiling;
    logic [rwu_pkg::DATA_W-1:0]   r_floor;

    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic en1, en2, en3, en4;

    // stage 1
    rwu_pkg::t_case               r1_case, n1_case;
    rwu_pkg::t_dir                r1_dir, n1_dir;
    logic [rwu_pkg::FACTOR_W-1:0] r1_factor, n1_factor;
    logic [rwu_pkg::DATA_W-1:0]   r1_step;
    logic [rwu_pkg::DATA_W-1:0]   r1_w;
    logic [rwu_pkg::DATA_W-1:0]   r1_sg;

    // stage 2
    rwu_pkg::t_case               r2_case;
    rwu_pkg::t_dir                r2_dir;
    logic [rwu_pkg::PROD_W-1:0]   r2_prod;
    logic [rwu_pkg::DATA_W-1:0]   r2_step;
    logic [rwu_pkg::DATA_W-1:0]   r2_w;
    logic [rwu_pkg::DATA_W-1:0]   r2_sg;

    // stage 3
    rwu_pkg::t_case               r3_case;
    rwu_pkg::t_dir                r3_dir;
    logic [rwu_pkg::DATA_W-1:0]   r3_new_step, n3_new_step;
    logic [rwu_pkg::DATA_W-1:0]   r3_move, n3_move;
    logic [rwu_pkg::DATA_W-1:0]   r3_w;
    logic [rwu_pkg::DATA_W-1:0]   r3_pg_out, n3_pg_out;

    // stage 4
    logic [rwu_pkg::DATA_W-1:0]   r4_w, n4_w;
    logic [rwu_pkg::DATA_W-1:0]   r4_step;
    logic [rwu_pkg::DATA_W-1:0]   r4_pg_out;

    logic                           pg_zero, sg_zero, pg_neg, sg_neg;
    logic [rwu_pkg::SCALED_W-1:0]   scaled;
    logic [rwu_pkg::DATA_W-1:0]     shrunk_sat;
    logic [rwu_pkg::DATA_W+1:0]     w_ext, mv_ext, sum;

    assign en4 = !r4_valid || o_result.ready;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;

    assign i_item.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grow    <= rwu_pkg::GROW_RESET;
            r_shrink  <= rwu_pkg::SHRINK_RESET;
            r_ceiling <= rwu_pkg::CEILING_RESET;
            r_floor   <= rwu_pkg::FLOOR_RESET;
        end else if (i_cfg_we) begin
            case (rwu_pkg::t_reg_idx'(i_cfg_idx))
                rwu_pkg::REG_GROW:    r_grow    <= i_cfg_data[rwu_pkg::FACTOR_W-1:0];
                rwu_pkg::REG_SHRINK:  r_shrink  <= i_cfg_data[rwu_pkg::FACTOR_W-1:0];
                rwu_pkg::REG_CEILING: r_ceiling <= i_cfg_data;
                rwu_pkg::REG_FLOOR:   r_floor   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // decode case and move direction from the gradient signs
    always_comb begin
        pg_zero = (i_item.prior_gradient == '0);
        sg_zero = (i_item.batch_gradient == '0);
        pg_neg  = i_item.prior_gradient[rwu_pkg::DATA_W-1];
        sg_neg  = i_item.batch_gradient[rwu_pkg::DATA_W-1];
        if (pg_zero || sg_zero) begin
            n1_case = rwu_pkg::CASE_HOLD;
        end else if (pg_neg == sg_neg) begin
            n1_case = rwu_pkg::CASE_GROW;
        end else begin
            n1_case = rwu_pkg::CASE_SHRINK;
        end
        n1_factor = (n1_case == rwu_pkg::CASE_SHRINK) ? r_shrink : r_grow;
        if (n1_case == rwu_pkg::CASE_SHRINK) begin
            n1_dir = pg_neg ? rwu_pkg::DIR_SUB : rwu_pkg::DIR_ADD;
        end else if (sg_zero) begin
            n1_dir = rwu_pkg::DIR_NONE;
        end else begin
            n1_dir = sg_neg ? rwu_pkg::DIR_ADD : rwu_pkg::DIR_SUB;
        end
    end

    // clamp the scaled step
    always_comb begin
        scaled     = r2_prod[rwu_pkg::PROD_W-1:rwu_pkg::FRAC_W];
        shrunk_sat = (|scaled[rwu_pkg::SCALED_W-1:rwu_pkg::DATA_W]) ? '1
                                                                   : scaled[rwu_pkg::DATA_W-1:0];
        n3_pg_out = r2_sg;
        case (r2_case)
            rwu_pkg::CASE_GROW: begin
                n3_new_step = (scaled > rwu_pkg::SCALED_W'(r_ceiling)) ? r_ceiling
                                                                       : scaled[rwu_pkg::DATA_W-1:0];
                n3_move     = n3_new_step;
            end
            rwu_pkg::CASE_SHRINK: begin
                n3_new_step = (shrunk_sat < r_floor) ? r_floor : shrunk_sat;
                n3_move     = r2_step;
                n3_pg_out   = '0;
            end
            default: begin
                n3_new_step = r2_step;
                n3_move     = r2_step;
            end
        endcase
    end

    // saturating weight move
    always_comb begin
        w_ext  = {{2{r3_w[rwu_pkg::DATA_W-1]}}, r3_w};
        mv_ext = {2'b00, r3_move};
        case (r3_dir)
            rwu_pkg::DIR_ADD: sum = w_ext + mv_ext;
            rwu_pkg::DIR_SUB: sum = w_ext - mv_ext;
            default:          sum = w_ext;
        endcase
        if (!sum[rwu_pkg::DATA_W+1] && (sum[rwu_pkg::DATA_W:rwu_pkg::DATA_W-1] != 2'b00)) begin
            n4_w = {1'b0, {(rwu_pkg::DATA_W-1){1'b1}}};
        end else if (sum[rwu_pkg::DATA_W+1] &&
                     (sum[rwu_pkg::DATA_W:rwu_pkg::DATA_W-1] != 2'b11)) begin
            n4_w = {1'b1, {(rwu_pkg::DATA_W-1){1'b0}}};
        end else begin
            n4_w = sum[rwu_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_item.valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_case   <= n1_case;
            r1_dir    <= n1_dir;
            r1_factor <= n1_factor;
            r1_step   <= i_item.step_in;
            r1_w      <= i_item.weight_in;
            r1_sg     <= i_item.batch_gradient;
        end
        if (en2) begin
            r2_case <= r1_case;
            r2_dir  <= r1_dir;
            r2_prod <= {{rwu_pkg::FACTOR_W{1'b0}}, r1_step} *
                       {{rwu_pkg::DATA_W{1'b0}}, r1_factor};
            r2_step <= r1_step;
            r2_w    <= r1_w;
            r2_sg   <= r1_sg;
        end
        if (en3) begin
            r3_case     <= r2_case;
            r3_dir      <= r2_dir;
            r3_new_step <= n3_new_step;
            r3_move     <= n3_move;
            r3_w        <= r2_w;
            r3_pg_out   <= n3_pg_out;
        end
        if (en4) begin
            r4_w      <= n4_w;
            r4_step   <= r3_new_step;
            r4_pg_out <= r3_pg_out;
        end
    end

    assign o_result.valid              = r4_valid;
    assign o_result.weight_out         = r4_w;
    assign o_result.step_out           = r4_step;
    assign o_result.prior_gradient_out = r4_pg_out;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r4_valid)
        else $error("output stage valid after reset");

    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r1_valid && r2_valid && r3_valid && r4_valid))
        else $error("input stalled with an empty stage");

    a_stage1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !en2) |=> r1_valid)
        else $error("stage 1 item dropped while stalled");

    a_advance_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && en3) |=> r3_valid)
        else $error("stage 2 item lost on advance");

    a_shrink_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && en4 && r3_case == rwu_pkg::CASE_SHRINK) |=> (r4_pg_out == '0))
        else $error("kept gradient not cleared after sign change");

endmodule
